// File: rtl/terrain_patch_index_generator_unit_defines.svh
// assertion macros for the terrain patch index generator checker
// no dependencies; included by the checker file only
`ifndef TERRAIN_PATCH_INDEX_GENERATOR_UNIT_DEFINES_SVH
`define TERRAIN_PATCH_INDEX_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define TPIG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TPIG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tpig_pkg.sv
// shared types, codes and corner offset table of the patch index generator
// no dependencies
`timescale 1ns / 1ps

package tpig_pkg;

   typedef enum logic [3:0] {
      REG_LEFT     = 4'd0,
      REG_RIGHT    = 4'd1,
      REG_UP       = 4'd2,
      REG_DOWN     = 4'd3,
      REG_LU       = 4'd4,
      REG_RU       = 4'd5,
      REG_LD       = 4'd6,
      REG_RD       = 4'd7,
      REG_INTERIOR = 4'd8
   } region_type;

   localparam int NUM_REGIONS = 9;

   localparam logic [3:0] EDGE_MASK_RESET = 4'hF;

   // corner modes: bit0 horizontal side set, bit1 vertical side set
   localparam logic [1:0] CORNER_BOTH_CUT  = 2'd0;
   localparam logic [1:0] CORNER_VERT_CUT  = 2'd1;
   localparam logic [1:0] CORNER_HORZ_CUT  = 2'd2;
   localparam logic [1:0] CORNER_NONE      = 2'd3;

   typedef struct packed {
      region_type  region;
      logic [2:0]  tig;
   } phase_type;

   typedef struct packed {
      logic        last;
      logic [8:0]  vc;
      logic [8:0]  vb;
      logic [8:0]  va;
   } result_type;

   typedef struct packed {
      logic signed [1:0] dx;
      logic signed [1:0] dy;
   } offset_type;

   typedef offset_type [2:0] corner_row_type;

   function automatic logic [1:0] corner_mode(region_type r, logic [3:0] mask);
      logic h;
      logic v;
      h = (r == REG_LU || r == REG_LD) ? mask[0] : mask[1];
      v = (r == REG_LU || r == REG_RU) ? mask[2] : mask[3];
      return {v, h};
   endfunction

   function automatic logic [2:0] corner_size(logic [1:0] m);
      return (m == CORNER_VERT_CUT || m == CORNER_HORZ_CUT) ? 3'd3 : 3'd4;
   endfunction

   function automatic offset_type ofs(int x, int y);
      offset_type o;
      o.dx = 2'(x);
      o.dy = 2'(y);
      return o;
   endfunction

   // entry [j] is vertex j of the triangle
   function automatic corner_row_type corner_row(logic [1:0] k, logic [1:0] t);
      corner_row_type r;
      r = '0;
      case ({k, t})
         4'b00_00: r = {ofs(-1, 0),  ofs(-1, -1), ofs(0, 0)};
         4'b00_01: r = {ofs(1, 0),   ofs(0, 0),   ofs(1, -1)};
         4'b00_10: r = {ofs(-1, -1), ofs(1, -1),  ofs(0, 0)};
         4'b01_00: r = {ofs(-1, 1),  ofs(0, 0),   ofs(0, 1)};
         4'b01_01: r = {ofs(-1, 1),  ofs(-1, -1), ofs(0, 0)};
         4'b01_10: r = {ofs(0, -1),  ofs(0, 0),   ofs(-1, -1)};
         4'b10_00: r = {ofs(0, 1),   ofs(-1, 1),  ofs(0, 0)};
         4'b10_01: r = {ofs(1, 0),   ofs(0, 0),   ofs(1, -1)};
         4'b10_10: r = {ofs(-1, 1),  ofs(-1, -1), ofs(0, 0)};
         4'b10_11: r = {ofs(-1, -1), ofs(1, -1),  ofs(0, 0)};
         default:  r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/tpig_walk.sv
// position walker: moves the list position forward to the next triangle that
// exists under the current edge mask; uses tpig_pkg
`timescale 1ns / 1ps

module tpig_walk
   import tpig_pkg::*;
#(
   parameter int PATCH_SIZE = 17,
   localparam int CW = $clog2(PATCH_SIZE)
) (
   input  phase_type        phase_in,
   input  logic [CW-1:0]    outer_in,
   input  logic [CW-1:0]    inner_in,
   input  logic             restart,
   input  logic [3:0]       edge_mask,
   output phase_type        phase_out,
   output logic [CW-1:0]    outer_out,
   output logic [CW-1:0]    inner_out
);

   localparam logic [CW-1:0] ONE      = CW'(1);
   localparam logic [CW-1:0] STEPS    = CW'((PATCH_SIZE - 4) / 2);
   localparam logic [CW-1:0] MAX_FULL = CW'(PATCH_SIZE - 1);
   localparam logic [CW-1:0] MAX_CUT  = CW'(PATCH_SIZE - 2);

   region_type            cur_region;
   logic [2:0]            cur_t;
   logic [CW-1:0]         cur_o;
   logic [CW-1:0]         cur_i;
   logic [CW-1:0]         min_x;
   logic [CW-1:0]         min_y;
   logic [CW-1:0]         max_x;
   logic [CW-1:0]         max_y;
   logic                  stay;
   logic [2:0]            adj_t;
   logic [CW-1:0]         adj_o;
   logic [CW-1:0]         adj_i;
   logic [3:0]            start;
   logic [NUM_REGIONS-1:0] usable;
   region_type            pick;

   assign cur_region = restart ? REG_LEFT : phase_in.region;
   assign cur_t      = restart ? 3'd0 : phase_in.tig;
   assign cur_o      = restart ? '0 : outer_in;
   assign cur_i      = restart ? '0 : inner_in;

   assign min_x = edge_mask[0] ? '0 : ONE;
   assign min_y = edge_mask[3] ? '0 : ONE;
   assign max_x = edge_mask[1] ? MAX_FULL : MAX_CUT;
   assign max_y = edge_mask[2] ? MAX_FULL : MAX_CUT;

   // local adjustment within the current region
   always_comb begin
      logic [1:0] m;
      logic       wrap;
      stay  = 1'b0;
      adj_t = cur_t;
      adj_o = cur_o;
      adj_i = cur_i;
      wrap  = 1'b0;
      m     = corner_mode(cur_region, edge_mask);
      case (cur_region)
         REG_LEFT, REG_RIGHT, REG_UP, REG_DOWN: begin
            if (cur_t >= 3'd3) begin
               adj_t = 3'd0;
               adj_o = cur_o + ONE;
            end
            stay = !edge_mask[cur_region[1:0]] && (adj_o < STEPS);
         end
         REG_LU, REG_RU, REG_LD, REG_RD: begin
            stay = (m != CORNER_NONE) && (cur_t < corner_size(m));
         end
         REG_INTERIOR: begin
            if (adj_o < min_y) begin
               adj_o = min_y;
               adj_i = min_x;
               adj_t = 3'd0;
            end
            if (adj_o >= max_y) wrap = 1'b1;
            if (adj_i < min_x) begin
               adj_i = min_x;
               adj_t = 3'd0;
            end
            if (adj_t >= 3'd2) begin
               adj_t = 3'd0;
               adj_i = adj_i + ONE;
            end
            if (adj_i >= max_x) begin
               adj_o = adj_o + ONE;
               adj_i = min_x;
               adj_t = 3'd0;
            end
            if (adj_o >= max_y) wrap = 1'b1;
            stay = !wrap;
         end
         default: begin
            stay = 1'b0;
         end
      endcase
   end

   // first usable region from the one after the current, wrapping past interior
   always_comb begin
      for (int g = 0; g < NUM_REGIONS; g++) begin
         if (g < 4) begin
            usable[g] = !edge_mask[g];
         end else if (g < NUM_REGIONS - 1) begin
            usable[g] = corner_mode(region_type'(4'(g)), edge_mask) != CORNER_NONE;
         end else begin
            usable[g] = 1'b1;
         end
      end
      start = (cur_region == REG_INTERIOR) ? 4'd0 : 4'(cur_region + 4'd1);
      pick  = REG_INTERIOR;
      for (int g = NUM_REGIONS - 1; g >= 0; g--) begin
         if (4'(g) >= start && usable[g]) pick = region_type'(4'(g));
      end
   end

   always_comb begin
      if (stay) begin
         phase_out.region = cur_region;
         phase_out.tig    = adj_t;
         outer_out        = adj_o;
         inner_out        = adj_i;
      end else begin
         phase_out.region = pick;
         phase_out.tig    = 3'd0;
         outer_out        = (pick == REG_INTERIOR) ? min_y : '0;
         inner_out        = (pick == REG_INTERIOR) ? min_x : '0;
      end
   end

endmodule

// File: rtl/tpig_emit.sv
// triangle emitter: vertex indices and last flag for one list position
// uses tpig_pkg for region codes and the corner offset table
`timescale 1ns / 1ps

module tpig_emit
   import tpig_pkg::*;
#(
   parameter int PATCH_SIZE = 17,
   localparam int CW = $clog2(PATCH_SIZE)
) (
   input  phase_type        phase,
   input  logic [CW-1:0]    outer_step,
   input  logic [CW-1:0]    inner_step,
   input  logic [3:0]       edge_mask,
   output result_type       result
);

   localparam int IW  = $clog2(PATCH_SIZE * PATCH_SIZE);
   localparam int VCW = (IW > 9) ? IW : 9;
   localparam logic [CW-1:0] ONE = CW'(1);
   localparam logic [CW-1:0] TWO = CW'(2);
   localparam logic [CW-1:0] PM1 = CW'(PATCH_SIZE - 1);
   localparam logic [CW-1:0] PM2 = CW'(PATCH_SIZE - 2);

   function automatic logic [8:0] vtx(logic [CW-1:0] x, logic [CW-1:0] y);
      logic [VCW-1:0] s;
      s = VCW'(x) * VCW'(PATCH_SIZE) + VCW'(y);
      return s[8:0];
   endfunction

   function automatic logic [CW-1:0] shift(logic [CW-1:0] b, logic signed [1:0] d,
                                           logic neg);
      logic signed [1:0] e;
      e = neg ? -d : d;
      return b + {{(CW-2){e[1]}}, e};
   endfunction

   logic [CW-1:0] vx [3];
   logic [CW-1:0] vy [3];
   logic          last;

   always_comb begin
      logic [CW-1:0]  i0;
      logic [CW-1:0]  i1;
      logic [CW-1:0]  i2;
      logic [CW-1:0]  xb;
      logic [CW-1:0]  yb;
      logic           negx;
      logic           negy;
      logic           flip;
      logic [1:0]     m;
      logic [1:0]     k;
      corner_row_type row;
      logic [CW-1:0]  max_x;
      logic [CW-1:0]  max_y;
      logic [CW-1:0]  x1;
      logic [CW-1:0]  y1;
      i0    = TWO + {outer_step[CW-2:0], 1'b0};
      i1    = i0 + ONE;
      i2    = i0 + TWO;
      xb    = (phase.region == REG_LU || phase.region == REG_LD) ? ONE : PM2;
      yb    = (phase.region == REG_LD || phase.region == REG_RD) ? ONE : PM2;
      negx  = !(phase.region == REG_LU || phase.region == REG_LD);
      negy  = !(phase.region == REG_LD || phase.region == REG_RD);
      flip  = (phase.region == REG_LU || phase.region == REG_RD);
      m     = corner_mode(phase.region, edge_mask);
      k     = (m == CORNER_VERT_CUT) ? 2'd0 : (m == CORNER_HORZ_CUT) ? 2'd1 : 2'd2;
      row   = corner_row(k, phase.tig[1:0]);
      max_x = edge_mask[1] ? PM1 : PM2;
      max_y = edge_mask[2] ? PM1 : PM2;
      x1    = inner_step + ONE;
      y1    = outer_step + ONE;
      last  = 1'b0;
      for (int j = 0; j < 3; j++) begin
         vx[j] = '0;
         vy[j] = '0;
      end
      case (phase.region)
         REG_LEFT: begin
            case (phase.tig)
               3'd0: begin
                  vx[0] = ONE; vy[0] = i0; vx[1] = '0;  vy[1] = i0; vx[2] = ONE; vy[2] = i1;
               end
               3'd1: begin
                  vx[0] = '0;  vy[0] = i0; vx[1] = '0;  vy[1] = i2; vx[2] = ONE; vy[2] = i1;
               end
               default: begin
                  vx[0] = '0;  vy[0] = i2; vx[1] = ONE; vy[1] = i2; vx[2] = ONE; vy[2] = i1;
               end
            endcase
         end
         REG_RIGHT: begin
            case (phase.tig)
               3'd0: begin
                  vx[0] = PM2; vy[0] = i0; vx[1] = PM2; vy[1] = i1; vx[2] = PM1; vy[2] = i0;
               end
               3'd1: begin
                  vx[0] = PM1; vy[0] = i0; vx[1] = PM2; vy[1] = i1; vx[2] = PM1; vy[2] = i2;
               end
               default: begin
                  vx[0] = PM1; vy[0] = i2; vx[1] = PM2; vy[1] = i1; vx[2] = PM2; vy[2] = i2;
               end
            endcase
         end
         REG_UP: begin
            case (phase.tig)
               3'd0: begin
                  vx[0] = i0; vy[0] = PM1; vx[1] = i1; vy[1] = PM2; vx[2] = i0; vy[2] = PM2;
               end
               3'd1: begin
                  vx[0] = i1; vy[0] = PM2; vx[1] = i0; vy[1] = PM1; vx[2] = i2; vy[2] = PM1;
               end
               default: begin
                  vx[0] = i2; vy[0] = PM1; vx[1] = i2; vy[1] = PM2; vx[2] = i1; vy[2] = PM2;
               end
            endcase
         end
         REG_DOWN: begin
            case (phase.tig)
               3'd0: begin
                  vx[0] = i0; vy[0] = '0;  vx[1] = i0; vy[1] = ONE; vx[2] = i1; vy[2] = ONE;
               end
               3'd1: begin
                  vx[0] = i1; vy[0] = ONE; vx[1] = i2; vy[1] = '0;  vx[2] = i0; vy[2] = '0;
               end
               default: begin
                  vx[0] = i2; vy[0] = '0;  vx[1] = i1; vy[1] = ONE; vx[2] = i2; vy[2] = ONE;
               end
            endcase
         end
         REG_LU, REG_RU, REG_LD, REG_RD: begin
            // flipped corners swap the first two vertices
            for (int j = 0; j < 3; j++) begin
               vx[j] = shift(xb, row[j].dx, negx);
               vy[j] = shift(yb, row[j].dy, negy);
            end
            if (flip) begin
               vx[0] = shift(xb, row[1].dx, negx);
               vy[0] = shift(yb, row[1].dy, negy);
               vx[1] = shift(xb, row[0].dx, negx);
               vy[1] = shift(yb, row[0].dy, negy);
            end
         end
         default: begin
            vx[0] = inner_step;
            vy[0] = outer_step;
            if (phase.tig == 3'd0) begin
               vx[1] = inner_step; vy[1] = y1;
               vx[2] = x1;         vy[2] = y1;
            end else begin
               vx[1] = x1; vy[1] = y1;
               vx[2] = x1; vy[2] = outer_step;
               last  = (y1 == max_y) && (x1 == max_x);
            end
         end
      endcase
   end

   assign result.va   = vtx(vx[0], vy[0]);
   assign result.vb   = vtx(vx[1], vy[1]);
   assign result.vc   = vtx(vx[2], vy[2]);
   assign result.last = last;

endmodule

// File: rtl/tpig_skid.sv
// two-entry output register with skid stage for result words
// uses tpig_pkg for the result word type
`timescale 1ns / 1ps

module tpig_skid
   import tpig_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  result_type  in_word,
   output logic        out_valid,
   input  logic        out_ready,
   output result_type  out_word
);

   logic       out_valid_ff;
   logic       out_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type out_word_ff;
   result_type out_word_in;
   result_type skid_word_ff;
   result_type skid_word_in;
   logic       take;

   assign in_ready  = !skid_valid_ff;
   assign take      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (take) begin
         if (!out_valid_ff || out_ready) begin
            out_valid_in = 1'b1;
            out_word_in  = in_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = in_word;
         end
      end else if (out_ready) begin
         out_valid_in  = skid_valid_ff;
         out_word_in   = skid_word_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

// File: rtl/terrain_patch_index_generator_unit.sv
// Terrain patch index generator, top level: list position registers,
// edge mask register, walker, emitter and output skid. Uses tpig_pkg.
//
// Usage: each word accepted on the req_ channel asks for one triangle of the
// patch list; req_tdata[0] = 1 restarts the list at its first triangle. The
// rsp_ channel returns one word per request with three vertex indices in
// rsp_tdata and rsp_tlast high on the final triangle of the list, after which
// the list wraps. The user must write the edge mask through
// csr_wr_en/csr_wr_data only while no request is in flight; the block itself
// does not enforce it. The current position is kept and moved on to the next
// triangle that exists under the new mask. Results are registered after the
// walker and emitter logic. Throughput: one triangle per cycle while the
// receiver does not stall, set by the position update loop.
// Reset (synchronous, active high) returns to the start of the list, sets the
// edge mask to all sides at same detail and empties the output stage.
// When the receiver stalls, one further request is taken into the skid stage;
// req_tready then drops until the output drains.
`timescale 1ns / 1ps

module terrain_patch_index_generator_unit
   import tpig_pkg::*;
#(
   parameter int PATCH_SIZE = 17
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [0] restart, [7:1] zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,    // [8:0] vertex_a, [17:9] vertex_b, [26:18] vertex_c
   output logic         rsp_tlast,    // last_triangle
   input  logic         csr_wr_en,
   input  logic [3:0]   csr_wr_data   // edge_mask
);

   localparam int CW = $clog2(PATCH_SIZE);

   phase_type     phase_ff;
   phase_type     phase_in;
   logic [CW-1:0] outer_ff;
   logic [CW-1:0] outer_in;
   logic [CW-1:0] inner_ff;
   logic [CW-1:0] inner_in;
   logic [3:0]    edge_mask_ff;
   phase_type     norm_phase;
   logic [CW-1:0] norm_outer;
   logic [CW-1:0] norm_inner;
   result_type    tri_word;
   result_type    rsp_word;
   logic          accept;

   assign accept = req_tvalid && req_tready;

   tpig_walk #(.PATCH_SIZE(PATCH_SIZE)) u_walk (
      .phase_in  (phase_ff),
      .outer_in  (outer_ff),
      .inner_in  (inner_ff),
      .restart   (req_tdata[0]),
      .edge_mask (edge_mask_ff),
      .phase_out (norm_phase),
      .outer_out (norm_outer),
      .inner_out (norm_inner)
   );

   tpig_emit #(.PATCH_SIZE(PATCH_SIZE)) u_emit (
      .phase      (norm_phase),
      .outer_step (norm_outer),
      .inner_step (norm_inner),
      .edge_mask  (edge_mask_ff),
      .result     (tri_word)
   );

   tpig_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_word   (tri_word),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_word)
   );

   always_comb begin
      phase_in = phase_ff;
      outer_in = outer_ff;
      inner_in = inner_ff;
      if (accept) begin
         phase_in.region = norm_phase.region;
         phase_in.tig    = norm_phase.tig + 3'd1;
         outer_in        = norm_outer;
         inner_in        = norm_inner;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '{region: REG_LEFT, tig: 3'd0};
         outer_ff     <= '0;
         inner_ff     <= '0;
         edge_mask_ff <= EDGE_MASK_RESET;
      end else begin
         phase_ff <= phase_in;
         outer_ff <= outer_in;
         inner_ff <= inner_in;
         if (csr_wr_en) begin
            edge_mask_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_tdata = {5'd0, rsp_word.vc, rsp_word.vb, rsp_word.va};
   assign rsp_tlast = rsp_word.last;

endmodule

// File: rtl/tpig_checker.sv
// port-level checker for the terrain patch index generator, with its bind
// depends on terrain_patch_index_generator_unit_defines.svh
`timescale 1ns / 1ps
`include "terrain_patch_index_generator_unit_defines.svh"

module tpig_checker #(
   parameter int PATCH_SIZE = 17
) (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic         rsp_tlast
);

   localparam logic [8:0] P9  = 9'(PATCH_SIZE);
   localparam logic [8:0] P91 = 9'(PATCH_SIZE + 1);

   // final triangle is the lower half of the last interior cell
   `TPIG_ASSERT_NOW(a_last_cell, clock, reset, rsp_tvalid && rsp_tlast,
      (rsp_tdata[26:18] == 9'(rsp_tdata[8:0] + P9)) &&
      (rsp_tdata[17:9] == 9'(rsp_tdata[8:0] + P91)), "last word is not an interior cell")

   `TPIG_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid,
      "result valid right after reset")

   `TPIG_ASSERT_NEXT(a_one_cycle, clock, reset, req_tvalid && req_tready, rsp_tvalid,
      "no result one cycle after request")

   `TPIG_ASSERT_NOW(a_skid_full, clock, reset, !req_tready, rsp_tvalid,
      "request stalled with empty output")

   `TPIG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result word changed")

endmodule

bind terrain_patch_index_generator_unit tpig_checker #(.PATCH_SIZE(PATCH_SIZE)) u_tpig_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tlast   (rsp_tlast)
);
